>>> sv/cmdp_pkg.sv
// ----------------------------------------------------------------------------
// cmdp_pkg
// Shared types and constants of the velocity command frame parser.
// ----------------------------------------------------------------------------
package cmdp_pkg;

  localparam int unsigned FrameLen   = 24;
  localparam int unsigned PayloadLen = 20;
  localparam int unsigned SeqPos     = 4;
  localparam int unsigned VxPos      = 8;
  localparam int unsigned VyPos      = 12;
  localparam int unsigned ValidPos   = 16;
  localparam int unsigned CsumPos    = 20;

  localparam logic [31:0] MagicWord  = 32'h3143_5641;
  localparam logic [31:0] CsumSeed   = 32'hA5A5_1234;
  localparam logic [30:0] MaxSpeedRst = 31'h3F80_0000;

  typedef logic [4:0] fill_t;

  typedef enum logic [2:0] {
    STATUS_NONE     = 3'd0,
    STATUS_ACCEPTED = 3'd1,
    STATUS_CSUM_ERR = 3'd2,
    STATUS_FIELD_ERR = 3'd3,
    STATUS_STALE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESYNC,
    ST_CSUM,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // Control from the sequencer to the checksum unit.
  typedef struct packed {
    logic       load;
    logic       step;
    logic [7:0] data;
  } csum_ctrl_t;

endpackage

>>> sv/cmdp_if.sv
// ----------------------------------------------------------------------------
// cmdp_if
// Valid/ready channels of the velocity command frame parser.
// ----------------------------------------------------------------------------
interface cmdp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_tick;

  modport source (output valid, rx_byte, arrival_tick, input ready);
  modport sink   (input valid, rx_byte, arrival_tick, output ready);
endinterface

interface cmdp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] seq;
  logic [31:0] vx_bits;
  logic [31:0] vy_bits;
  logic        command_valid;
  logic        command_seen;
  logic [31:0] accept_tick;
  logic [31:0] generation;
  logic [31:0] frames_ok;
  logic [31:0] frames_bad;
  logic [31:0] csum_fails;

  modport source (output valid, status, seq, vx_bits, vy_bits, command_valid,
                  command_seen, accept_tick, generation, frames_ok,
                  frames_bad, csum_fails, input ready);
  modport sink   (input valid, status, seq, vx_bits, vy_bits, command_valid,
                  command_seen, accept_tick, generation, frames_ok,
                  frames_bad, csum_fails, output ready);
endinterface

interface cmdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] max_speed_bits;

  modport source (output valid, max_speed_bits, input ready);
  modport sink   (input valid, max_speed_bits, output ready);
endinterface

>>> sv/cmdp_csum.sv
// ----------------------------------------------------------------------------
// cmdp_csum
// Shift-xor checksum accumulator, one byte per step.
// ----------------------------------------------------------------------------
module cmdp_csum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmdp_pkg::csum_ctrl_t ctrl_i,
  output logic [31:0]          sum_o
);

  logic [31:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.load) begin
      sum_d = cmdp_pkg::CsumSeed;
    end else if (ctrl_i.step) begin
      sum_d = (sum_q << 5) ^ (sum_q >> 2) ^ {24'd0, ctrl_i.data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= cmdp_pkg::CsumSeed;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> sv/velocity_command_frame_parser.sv
// ----------------------------------------------------------------------------
// velocity_command_frame_parser
// Collects serial bytes into command frames, checks and accepts them.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  cmd_i   | in  | rx_byte, arrival_tick
//  res_o   | out | status and the command snapshot after the beat
//  cfg_i   | in  | max_speed_bits
//
// One byte passes the idle, resync and emit states when no frame completes, and
// resync drops one byte at a time while searching for the magic word. A complete
// frame adds the checksum unit pass (one byte a cycle) and then the field checks.
// The input is ready only while the sequencer is idle; a finished result waits
// in the output register, and the next byte is taken meanwhile. A second result
// holds the sequencer in its last state until the output register frees up.
// Reset clears all control state and the snapshot; no clearing pass is needed.
module velocity_command_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmdp_in_if.sink     cmd_i,
  cmdp_out_if.source  res_o,
  cmdp_cfg_if.sink    cfg_i
);

  cmdp_pkg::state_e   state_q, state_d;
  cmdp_pkg::status_e  st_q, st_d;
  cmdp_pkg::csum_ctrl_t csum_ctrl;

  logic [7:0]  buf_q [cmdp_pkg::FrameLen];
  cmdp_pkg::fill_t fill_q;
  logic [4:0]  idx_q;
  logic [31:0] tick_q;
  logic [30:0] max_q;
  logic [31:0] sum;

  logic        seq_seen_q, valid_flag_q, seen_flag_q;
  logic [31:0] last_seq_q, last_vx_q, last_vy_q, last_tick_q;
  logic [31:0] gen_q, ok_q, bad_q, crc_bad_q;

  logic        out_valid_q;
  logic        do_drop, do_clear, do_accept, do_stale, do_csum_err, do_field_err;
  logic        idx_clr, idx_inc, load_out;

  logic [31:0] magic, seq_w, vx_w, vy_w, csum_w, seq_diff;
  logic        in_fire;

  assign magic  = {buf_q[3], buf_q[2], buf_q[1], buf_q[0]};
  assign seq_w  = {buf_q[cmdp_pkg::SeqPos+3], buf_q[cmdp_pkg::SeqPos+2],
                   buf_q[cmdp_pkg::SeqPos+1], buf_q[cmdp_pkg::SeqPos]};
  assign vx_w   = {buf_q[cmdp_pkg::VxPos+3], buf_q[cmdp_pkg::VxPos+2],
                   buf_q[cmdp_pkg::VxPos+1], buf_q[cmdp_pkg::VxPos]};
  assign vy_w   = {buf_q[cmdp_pkg::VyPos+3], buf_q[cmdp_pkg::VyPos+2],
                   buf_q[cmdp_pkg::VyPos+1], buf_q[cmdp_pkg::VyPos]};
  assign csum_w = {buf_q[cmdp_pkg::CsumPos+3], buf_q[cmdp_pkg::CsumPos+2],
                   buf_q[cmdp_pkg::CsumPos+1], buf_q[cmdp_pkg::CsumPos]};
  assign seq_diff = seq_w - last_seq_q;

  assign cmd_i.ready = (state_q == cmdp_pkg::ST_IDLE);
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  cmdp_csum u_csum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (csum_ctrl),
    .sum_o  (sum)
  );

  always_comb begin
    state_d      = state_q;
    st_d         = st_q;
    do_drop      = 1'b0;
    do_clear     = 1'b0;
    do_accept    = 1'b0;
    do_stale     = 1'b0;
    do_csum_err  = 1'b0;
    do_field_err = 1'b0;
    idx_clr      = 1'b0;
    idx_inc      = 1'b0;
    load_out     = 1'b0;
    csum_ctrl.load = 1'b0;
    csum_ctrl.step = 1'b0;
    csum_ctrl.data = buf_q[idx_q];
    case (state_q)
      cmdp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = cmdp_pkg::ST_RESYNC;
        end
      end
      cmdp_pkg::ST_RESYNC: begin
        if (fill_q >= 5'd4 && magic != cmdp_pkg::MagicWord) begin
          do_drop = 1'b1;
        end else if (fill_q == 5'(cmdp_pkg::FrameLen)) begin
          csum_ctrl.load = 1'b1;
          idx_clr        = 1'b1;
          state_d        = cmdp_pkg::ST_CSUM;
        end else begin
          st_d    = cmdp_pkg::STATUS_NONE;
          state_d = cmdp_pkg::ST_EMIT;
        end
      end
      cmdp_pkg::ST_CSUM: begin
        csum_ctrl.step = 1'b1;
        idx_inc        = 1'b1;
        if (idx_q == 5'(cmdp_pkg::PayloadLen - 1)) begin
          state_d = cmdp_pkg::ST_CHECK;
        end
      end
      cmdp_pkg::ST_CHECK: begin
        state_d = cmdp_pkg::ST_EMIT;
        if (sum != csum_w) begin
          do_csum_err = 1'b1;
          do_drop     = 1'b1;
          st_d        = cmdp_pkg::STATUS_CSUM_ERR;
        end else if (buf_q[cmdp_pkg::ValidPos] > 8'd1 || buf_q[17] != 8'd0 ||
                     buf_q[18] != 8'd0 || buf_q[19] != 8'd0 ||
                     vx_w[30:23] == 8'hFF || vy_w[30:23] == 8'hFF) begin
          do_field_err = 1'b1;
          do_drop      = 1'b1;
          st_d         = cmdp_pkg::STATUS_FIELD_ERR;
        end else begin
          do_clear = 1'b1;
          // A sequence number is newer when the signed difference is positive.
          if (seq_seen_q && (seq_diff == 32'd0 || seq_diff[31])) begin
            do_stale = 1'b1;
            st_d     = cmdp_pkg::STATUS_STALE;
          end else begin
            do_accept = 1'b1;
            st_d      = cmdp_pkg::STATUS_ACCEPTED;
          end
        end
      end
      cmdp_pkg::ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = cmdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cmdp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmdp_pkg::ST_IDLE;
      st_q    <= cmdp_pkg::STATUS_NONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // Frame buffer: append at the fill point, shift down by one on a drop.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (fill_q >= 5'(cmdp_pkg::FrameLen)) begin
        buf_q[cmdp_pkg::FrameLen-1] <= cmd_i.rx_byte;
      end else begin
        buf_q[fill_q] <= cmd_i.rx_byte;
      end
      tick_q <= cmd_i.arrival_tick;
    end else if (do_drop) begin
      for (int i = 0; i < cmdp_pkg::FrameLen - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      max_q  <= cmdp_pkg::MaxSpeedRst;
    end else begin
      if (in_fire) begin
        if (fill_q >= 5'(cmdp_pkg::FrameLen)) begin
          fill_q <= 5'(cmdp_pkg::FrameLen);
        end else begin
          fill_q <= fill_q + 5'd1;
        end
      end else if (do_drop) begin
        fill_q <= (fill_q <= 5'd1) ? 5'd0 : fill_q - 5'd1;
      end else if (do_clear) begin
        fill_q <= '0;
      end
      if (idx_clr) begin
        idx_q <= '0;
      end else if (idx_inc) begin
        idx_q <= idx_q + 5'd1;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        max_q <= cfg_i.max_speed_bits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_seen_q   <= 1'b0;
      valid_flag_q <= 1'b0;
      seen_flag_q  <= 1'b0;
      last_seq_q   <= '0;
      last_vx_q    <= '0;
      last_vy_q    <= '0;
      last_tick_q  <= '0;
      gen_q        <= '0;
      ok_q         <= '0;
      bad_q        <= '0;
      crc_bad_q    <= '0;
    end else begin
      if (do_csum_err) begin
        crc_bad_q <= crc_bad_q + 32'd1;
      end
      if (do_csum_err || do_field_err || do_stale) begin
        bad_q <= bad_q + 32'd1;
      end
      if (do_accept) begin
        seq_seen_q   <= 1'b1;
        seen_flag_q  <= 1'b1;
        last_seq_q   <= seq_w;
        last_vx_q    <= (vx_w[30:0] > max_q) ? {vx_w[31], max_q} : vx_w;
        last_vy_q    <= (vy_w[30:0] > max_q) ? {vy_w[31], max_q} : vy_w;
        valid_flag_q <= (buf_q[cmdp_pkg::ValidPos] == 8'd1);
        last_tick_q  <= tick_q;
        gen_q        <= gen_q + 32'd1;
        ok_q         <= ok_q + 32'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_o.status        <= st_q;
      res_o.seq           <= last_seq_q;
      res_o.vx_bits       <= last_vx_q;
      res_o.vy_bits       <= last_vy_q;
      res_o.command_valid <= valid_flag_q;
      res_o.command_seen  <= seen_flag_q;
      res_o.accept_tick   <= last_tick_q;
      res_o.generation    <= gen_q;
      res_o.frames_ok     <= ok_q;
      res_o.frames_bad    <= bad_q;
      res_o.csum_fails    <= crc_bad_q;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule
